>>> hw/rtl/mt19937_64_generator_macros.svh
// assertion macros shared by the checker of the mt19937-64 generator
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef MT19937_64_GENERATOR_MACROS_SVH
`define MT19937_64_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mtg_pkg.sv
// types, constants and the tempering function of the mt19937-64 generator
// no dependencies
package mtg_pkg;

  localparam int unsigned StateWords   = 312;
  localparam int unsigned MiddleOffset = 156;
  localparam int unsigned IdxW         = $clog2(StateWords);

  localparam logic [63:0] TwistCoef = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] HighMask  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LowMask   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SeedMult  = 64'd6364136223846793005;
  localparam logic [63:0] TemperB   = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TemperC   = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TemperD   = 64'hFFF7_EEE0_0000_0000;
  localparam logic [63:0] ResetSeed = 64'd5489;

  // operation code carried in tuser
  typedef enum logic {
    OP_SEED = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  // output tempering
  function automatic logic [63:0] temper(input logic [63:0] x);
    logic [63:0] t;
    t = x;
    t = t ^ ((t >> 29) & TemperB);
    t = t ^ ((t << 17) & TemperC);
    t = t ^ ((t << 37) & TemperD);
    t = t ^ (t >> 43);
    return t;
  endfunction

endpackage

>>> hw/rtl/mt19937_64_generator.sv
// mt19937-64 generator: 312-word state in one ram, lazy one-word twist per draw
// a draw reads the next word at its input transaction, then the middle word, then
// twists, writes back and registers the tempered output; the input reopens in idle, so
// a new transaction is taken only once the result is registered; a stalled result holds.
// a seed computes each word in two steps (split 64-bit multiply, then add).
// reset clears control state and sets default_seed to 5489; ram content is undefined
module mt19937_64_generator
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
  input  logic        s_axis_tuser,   // [0] operation
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] random_value
  // default seed register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SD_MUL = 7'b0000010,
    ST_SD_ADD = 7'b0000100,
    ST_DR_NXT = 7'b0001000,
    ST_DR_MID = 7'b0010000,
    ST_DR_WR  = 7'b0100000,
    ST_DR_OUT = 7'b1000000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(StateWords - 1);
  localparam logic [IdxW-1:0] MidIdx  = IdxW'(MiddleOffset);

  state_e state_q, state_d;

  logic [63:0]     dflt_seed_q;
  logic            seeded_q, seeded_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] sidx_q, sidx_d;
  logic [63:0]     cur_q, cur_d;
  logic [63:0]     prev_q, prev_d;
  logic [63:0]     nxt_word_q, nxt_word_d;
  logic [63:0]     twist_q, twist_d;
  logic [63:0]     p0_q;
  logic [31:0]     p1_q, p2_q;
  logic            out_vld_q, out_vld_d;
  logic [63:0]     out_q, out_d;

  logic            in_acc, out_free;
  logic [IdxW-1:0] nxt_idx, mid_idx;
  logic [63:0]     xx, seed_word, y_word, twist_word, in_seed;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_rdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // default seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_seed_q <= ResetSeed;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dflt_seed_q <= cfg_data_i;
    end
  end

  // neighbor addresses of the draw position
  assign nxt_idx = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
  assign mid_idx = (pos_q < MidIdx) ? pos_q + MidIdx : pos_q - MidIdx;

  // seed recurrence, split into 32x32 partial products
  assign xx        = prev_q ^ (prev_q >> 62);
  assign seed_word = p0_q + {p1_q + p2_q, 32'd0} + {{(64 - IdxW){1'b0}}, sidx_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SD_MUL) begin
      p0_q <= SeedMult[31:0] * xx[31:0];
      p1_q <= 32'(SeedMult[63:32] * xx[31:0]);
      p2_q <= 32'(SeedMult[31:0] * xx[63:32]);
    end
  end

  // twist of the word at the draw position; ram_rdata holds the middle word
  assign y_word     = (cur_q & HighMask) | (nxt_word_q & LowMask);
  assign twist_word = ram_rdata ^ (y_word >> 1) ^ (y_word[0] ? TwistCoef : 64'd0);

  assign in_seed = (op_e'(s_axis_tuser) == OP_SEED) ? s_axis_tdata : dflt_seed_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    seeded_d   = seeded_q;
    pend_d     = pend_q;
    pos_d      = pos_q;
    sidx_d     = sidx_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    nxt_word_d = nxt_word_q;
    twist_d    = twist_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = twist_word;
    ram_raddr  = nxt_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_e'(s_axis_tuser) == OP_DRAW && seeded_q) begin
            state_d = ST_DR_MID;
          end else begin
            // word 0 takes the seed; the rest follows the recurrence
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_seed;
            cur_d     = in_seed;
            prev_d    = in_seed;
            pos_d     = '0;
            sidx_d    = IdxW'(1);
            seeded_d  = 1'b1;
            pend_d    = (op_e'(s_axis_tuser) == OP_DRAW);
            state_d   = ST_SD_MUL;
          end
        end
      end
      ST_SD_MUL: begin
        state_d = ST_SD_ADD;
      end
      ST_SD_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = sidx_q;
        ram_wdata = seed_word;
        prev_d    = seed_word;
        sidx_d    = sidx_q + 1'b1;
        if (sidx_q == LastIdx) begin
          state_d = pend_q ? ST_DR_NXT : ST_IDLE;
          pend_d  = 1'b0;
        end else begin
          state_d = ST_SD_MUL;
        end
      end
      ST_DR_NXT: begin
        state_d = ST_DR_MID;
      end
      ST_DR_MID: begin
        ram_raddr  = mid_idx;
        nxt_word_d = ram_rdata;
        state_d    = ST_DR_WR;
      end
      ST_DR_WR: begin
        ram_we  = 1'b1;
        cur_d   = nxt_word_q;
        pos_d   = nxt_idx;
        twist_d = twist_word;
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = temper(twist_word);
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = temper(twist_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seeded_q  <= 1'b0;
      pend_q    <= 1'b0;
      pos_q     <= '0;
      sidx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seeded_q  <= seeded_d;
      pend_q    <= pend_d;
      pos_q     <= pos_d;
      sidx_q    <= sidx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_word_q <= nxt_word_d;
    twist_q    <= twist_d;
    out_q      <= out_d;
  end

  // word store
  mtg_ram #(
    .Width(64),
    .Depth(StateWords)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

>>> hw/rtl/mtg_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module mtg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 312
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/mtg_checker.sv
// port-level checker for the mt19937-64 generator, bound to the top level
// depends on mtg_pkg and mt19937_64_generator_macros.svh
`include "mt19937_64_generator_macros.svh"

module mtg_checker
  import mtg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds its value
  `MTG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")

  // one transaction at a time: the input closes right after an accept
  `MTG_ASSERT_NEXT(a_in_busy, in_acc, !s_axis_tready, "input ready right after accept")

  // a seed transaction never produces a result
  `MTG_ASSERT_NEXT(a_seed_quiet, in_acc && s_axis_tuser == OP_SEED && !m_axis_tvalid, !m_axis_tvalid, "result after seed")

  // a result only appears while the block is busy with a draw
  `MTG_ASSERT_NOW(a_out_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without a draw in flight")

endmodule

bind mt19937_64_generator mtg_checker u_mtg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
